>>> design/spf_pkg.sv
// shared types and constants of the slot pool free list
package spf_pkg;

    localparam int unsigned KIND_W   = 1;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned REV_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NOT_LIVE  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [REV_W-1:0]    revision;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
    } t_rsp;

endpackage

>>> design/spf_chan_if.sv
// valid/ready channel carrying one payload per transaction
interface spf_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/slot_pool_free_list.sv
// slot pool free list: allocate pops a free slot and bumps its revision, release pushes it back
// request and memory reads registered on acceptance; result registered once the output is free
// each item completes before the next is taken, set by the synchronous read of the link memory
// a new request is taken while the previous result still waits in the output register
// reset: synchronous, clears control only; no clearing pass, a fill counter stands in
// for the initial chain, so the block takes requests from the first cycle after reset
module slot_pool_free_list #(
    parameter int unsigned POOL_DEPTH    = 1024,
    parameter int unsigned REVISION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spf_chan_if.sink    i_req,
    spf_chan_if.source  o_rsp
);

    localparam int unsigned IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int unsigned CMP_W  = (LINK_W > spf_pkg::SLOT_W) ? LINK_W : spf_pkg::SLOT_W;
    localparam int unsigned OUT_REV_W = spf_pkg::REV_W;
    localparam int unsigned OUT_CNT_W = spf_pkg::COUNT_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

    // memories: free links, and live bit over revision per slot
    logic [LINK_W-1:0]        r_link_mem [POOL_DEPTH];
    logic [REVISION_BITS:0]   r_rev_mem  [POOL_DEPTH];
    logic [LINK_W-1:0]        r_link_q;
    logic [REVISION_BITS:0]   r_rev_q;

    spf_pkg::t_state          r_state, n_state;
    logic [spf_pkg::KIND_W-1:0] r_kind;
    logic [spf_pkg::SLOT_W-1:0] r_slot;
    logic [LINK_W-1:0]        r_head, n_head;   // top of released stack, null when empty
    logic [LINK_W-1:0]        r_fill, n_fill;   // slots below this were handed out at least once
    logic [LINK_W-1:0]        r_live, n_live;
    spf_pkg::t_rsp            r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     accept;
    logic                     rd_en;
    logic                     done;
    logic                     rev_we;
    logic                     link_we;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic [REVISION_BITS:0]   rev_wdata;

    logic                     head_empty;
    logic                     exhausted;
    logic [IDX_W-1:0]         alloc_idx;
    logic [IDX_W-1:0]         in_slot_idx;
    logic [IDX_W-1:0]         cur_slot_idx;
    logic [CMP_W-1:0]         cur_slot_ext;
    logic [CMP_W-1:0]         alloc_ext;
    logic                     release_ok;
    logic [REVISION_BITS-1:0] rev_old;
    logic [REVISION_BITS-1:0] rev_new;

    assign head_empty   = (r_head == NULL_LINK);
    assign exhausted    = head_empty && (r_fill == NULL_LINK);
    assign alloc_idx    = head_empty ? r_fill[IDX_W-1:0] : r_head[IDX_W-1:0];
    assign in_slot_idx  = IDX_W'(CMP_W'(i_req.payload.slot));
    assign cur_slot_ext = CMP_W'(r_slot);
    assign cur_slot_idx = cur_slot_ext[IDX_W-1:0];
    assign alloc_ext    = CMP_W'(alloc_idx);
    // anything at or beyond the fill mark was never handed out, hence not live
    assign release_ok   = (cur_slot_ext < CMP_W'(r_fill)) && r_rev_q[REVISION_BITS];
    // a slot taken fresh from the fill region still has revision zero
    assign rev_old      = head_empty ? '0 : r_rev_q[REVISION_BITS-1:0];
    assign rev_new      = rev_old + REVISION_BITS'(1);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_live      = r_live;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        i_req.ready = 1'b0;
        accept      = 1'b0;
        rd_en       = 1'b0;
        done        = 1'b0;
        rev_we      = 1'b0;
        link_we     = 1'b0;
        rd_idx      = alloc_idx;
        wr_idx      = alloc_idx;
        rev_wdata   = {1'b1, rev_new};

        case (r_state)
            spf_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                accept      = i_req.valid;
                rd_en       = accept;
                if (i_req.payload.kind == spf_pkg::KIND_RELEASE) begin
                    rd_idx = in_slot_idx;
                end
                if (accept) begin
                    n_state = spf_pkg::S_EXEC;
                end
            end
            spf_pkg::S_EXEC: begin
                done = !r_out_valid || o_rsp.ready;
                if (done) begin
                    n_state     = spf_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_kind == spf_pkg::KIND_ALLOC) begin
                        if (exhausted) begin
                            n_out.slot_index = '0;
                            n_out.revision   = '0;
                            n_out.status     = spf_pkg::ST_EXHAUSTED;
                        end else begin
                            rev_we = 1'b1;
                            if (head_empty) begin
                                n_fill = r_fill + LINK_W'(1);
                            end else begin
                                n_head = r_link_q;
                            end
                            n_live           = r_live + LINK_W'(1);
                            n_out.slot_index = alloc_ext[spf_pkg::SLOT_W-1:0];
                            n_out.revision   = OUT_REV_W'(rev_new);
                            n_out.status     = spf_pkg::ST_OK;
                        end
                    end else begin
                        wr_idx    = cur_slot_idx;
                        rev_wdata = {1'b0, r_rev_q[REVISION_BITS-1:0]};
                        if (release_ok) begin
                            rev_we           = 1'b1;
                            link_we          = 1'b1;
                            n_head           = LINK_W'(cur_slot_idx);
                            n_live           = (r_live != '0) ? r_live - LINK_W'(1) : r_live;
                            n_out.slot_index = r_slot;
                            n_out.revision   = OUT_REV_W'(r_rev_q[REVISION_BITS-1:0]);
                            n_out.status     = spf_pkg::ST_OK;
                        end else begin
                            n_out.slot_index = '0;
                            n_out.revision   = '0;
                            n_out.status     = spf_pkg::ST_NOT_LIVE;
                        end
                    end
                    n_out.live_count = OUT_CNT_W'(n_live);
                end
            end
            default: begin
                n_state = spf_pkg::S_IDLE;
            end
        endcase
    end

    // memory ports: one read per memory on the request transaction, write on completion
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rev_q  <= r_rev_mem[rd_idx];
            r_link_q <= r_link_mem[r_head[IDX_W-1:0]];
        end
        if (rev_we) begin
            r_rev_mem[wr_idx] <= rev_wdata;
        end
        if (link_we) begin
            r_link_mem[cur_slot_idx] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spf_pkg::S_IDLE;
            r_head      <= NULL_LINK;
            r_fill      <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.payload.kind;
            r_slot <= i_req.payload.slot;
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // live slots are a subset of those handed out from the fill region
    a_live_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_fill)
        else $error("live count above fill mark");

    // the released stack only ever holds slots below the fill mark
    a_head_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !head_empty |-> (r_head < r_fill))
        else $error("free head beyond fill mark");

    // an exhausted pool means every slot is live
    a_exhaust_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_EXEC && r_kind == spf_pkg::KIND_ALLOC && exhausted)
        |-> (r_live == NULL_LINK))
        else $error("pool exhausted with free slots left");

    // a completed item leaves a result waiting in the output register
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && r_state == spf_pkg::S_IDLE))
        else $error("completed item without result");

endmodule

>>> sim/tb.sv
// self-checking testbench for the slot pool free list: predicts every reply and compares it
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_W        = spf_pkg::SLOT_W;
    localparam int unsigned REV_W         = spf_pkg::REV_W;
    localparam int unsigned COUNT_W       = spf_pkg::COUNT_W;
    localparam int unsigned POOL_SIZE     = 1024;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned RECYCLE_ROUNDS = 20;
    localparam int unsigned RELEASE_ITEMS = 60;
    localparam int unsigned RANDOM_ITEMS  = 100;

    logic i_clk;
    logic i_rst_n;

    spf_chan_if #(.t_payload(spf_pkg::t_req)) req_if ();
    spf_chan_if #(.t_payload(spf_pkg::t_rsp)) rsp_if ();

    slot_pool_free_list #(
        .POOL_DEPTH    (POOL_SIZE),
        .REVISION_BITS (REV_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted pool state
    logic [COUNT_W-1:0] pool_link [POOL_SIZE];
    logic [REV_W-1:0]   pool_rev  [POOL_SIZE];
    logic               pool_live [POOL_SIZE];
    logic [COUNT_W-1:0] pool_head;
    logic [COUNT_W-1:0] pool_live_total;

    spf_pkg::t_rsp     replies_due [$];
    logic [SLOT_W-1:0] held_slots  [$];

    int unsigned error_count;
    int unsigned reply_count;
    bit          calm_traffic;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void init_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_link[i] = COUNT_W'(i + 1);
            pool_rev[i]  = '0;
            pool_live[i] = 1'b0;
        end
        pool_head       = '0;
        pool_live_total = '0;
    endfunction

    function automatic spf_pkg::t_rsp predict_pool_op(spf_pkg::t_req req);
        spf_pkg::t_rsp     rsp;
        logic [SLOT_W-1:0] s;
        rsp = '0;
        if (req.kind == spf_pkg::KIND_ALLOC) begin
            if (pool_head >= POOL_SIZE) begin
                rsp.status = spf_pkg::ST_EXHAUSTED;
            end else begin
                s               = pool_head[SLOT_W-1:0];
                pool_rev[s]     = pool_rev[s] + 1'b1;
                pool_head       = pool_link[s];
                pool_live[s]    = 1'b1;
                pool_live_total = pool_live_total + 1'b1;
                rsp.slot_index  = s;
                rsp.revision    = pool_rev[s];
                rsp.status      = spf_pkg::ST_OK;
            end
        end else begin
            s = req.slot;
            if (!pool_live[s]) begin
                rsp.status = spf_pkg::ST_NOT_LIVE;
            end else begin
                pool_link[s] = pool_head;
                pool_head    = COUNT_W'(s);
                pool_live[s] = 1'b0;
                if (pool_live_total > 0)
                    pool_live_total = pool_live_total - 1'b1;
                rsp.slot_index = s;
                rsp.revision   = pool_rev[s];
                rsp.status     = spf_pkg::ST_OK;
            end
        end
        rsp.live_count = pool_live_total;
        return rsp;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm_traffic)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("reply %0d: %s got %0d expected %0d", reply_count, field, got, want);
        error_count++;
    endtask

    // called at a rising edge; returns at the edge after the transaction (and any gap)
    task automatic send_item(input spf_pkg::t_kind kind, input logic [SLOT_W-1:0] slot);
        spf_pkg::t_req req;
        spf_pkg::t_rsp want;
        int            gap;
        req.kind = kind;
        req.slot = slot;
        req_if.valid   <= 1'b1;
        req_if.payload <= req;
        do @(posedge i_clk); while (!req_if.ready);
        want = predict_pool_op(req);
        replies_due.push_back(want);
        if (kind == spf_pkg::KIND_ALLOC && want.status == spf_pkg::ST_OK) begin
            held_slots.push_back(want.slot_index);
        end else if (kind == spf_pkg::KIND_RELEASE && want.status == spf_pkg::ST_OK) begin
            for (int i = 0; i < held_slots.size(); i++) begin
                if (held_slots[i] == slot) begin
                    held_slots.delete(i);
                    break;
                end
            end
        end
        gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic release_random_held();
        int idx;
        idx = $urandom_range(0, held_slots.size() - 1);
        send_item(spf_pkg::KIND_RELEASE, held_slots[idx]);
    endtask

    task automatic test_directed();
        send_item(spf_pkg::KIND_ALLOC, '0);
        send_item(spf_pkg::KIND_ALLOC, '1);
        // never allocated, top index
        send_item(spf_pkg::KIND_RELEASE, 10'd1023);
        send_item(spf_pkg::KIND_RELEASE, 10'd0);
        // double release
        send_item(spf_pkg::KIND_RELEASE, 10'd0);
        // lifo: slot 0 comes back with the next revision
        send_item(spf_pkg::KIND_ALLOC, 10'h2aa);
        send_item(spf_pkg::KIND_ALLOC, 10'h155);
        send_item(spf_pkg::KIND_RELEASE, 10'd1);
        send_item(spf_pkg::KIND_RELEASE, 10'd2);
        send_item(spf_pkg::KIND_RELEASE, 10'h2aa);
        send_item(spf_pkg::KIND_RELEASE, 10'h155);
        send_item(spf_pkg::KIND_RELEASE, 10'd0);
        send_item(spf_pkg::KIND_ALLOC, '1);
        send_item(spf_pkg::KIND_ALLOC, '0);
        send_item(spf_pkg::KIND_ALLOC, 10'h3f0);
        send_item(spf_pkg::KIND_RELEASE, 10'd1);
        send_item(spf_pkg::KIND_RELEASE, 10'd1);
        send_item(spf_pkg::KIND_ALLOC, 10'h00f);
    endtask

    // one slot cycled through alloc and release, its revision climbing each round
    task automatic test_slot_recycle();
        spf_pkg::t_rsp last;
        calm_traffic = 1'b1;
        for (int n = 0; n < RECYCLE_ROUNDS; n++) begin
            send_item(spf_pkg::KIND_ALLOC, SLOT_W'($urandom_range(0, 1023)));
            last = replies_due[$];
            send_item(spf_pkg::KIND_RELEASE, last.slot_index);
        end
        calm_traffic = 1'b0;
    endtask

    task automatic test_exhaust_and_drain();
        logic [SLOT_W-1:0] s;
        while (held_slots.size() < POOL_SIZE)
            send_item(spf_pkg::KIND_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        repeat (3) send_item(spf_pkg::KIND_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        release_random_held();
        send_item(spf_pkg::KIND_ALLOC, '0);
        send_item(spf_pkg::KIND_ALLOC, '1);
        s = held_slots[$urandom_range(0, held_slots.size() - 1)];
        send_item(spf_pkg::KIND_RELEASE, s);
        send_item(spf_pkg::KIND_RELEASE, s);
        for (int n = 0; n < RELEASE_ITEMS && held_slots.size() > 0; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(spf_pkg::KIND_RELEASE, SLOT_W'($urandom_range(0, 1023)));
            else
                release_random_held();
        end
        send_item(spf_pkg::KIND_RELEASE, SLOT_W'($urandom_range(0, 1023)));
    endtask

    // receiver holds off while items keep coming, so the block fills and stalls its input
    task automatic test_backpressure();
        calm_traffic = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 30; n++) begin
            if (n % 3 == 2 && held_slots.size() > 0)
                release_random_held();
            else
                send_item(spf_pkg::KIND_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        end
        calm_traffic = 1'b0;
    endtask

    task automatic test_random_traffic();
        int alloc_pct;
        int r;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_traffic = ((n / 25) % 4 == 3);
            case ((n / 34) % 3)
                0:       alloc_pct = 85;
                1:       alloc_pct = 50;
                default: alloc_pct = 20;
            endcase
            r = $urandom_range(0, 99);
            if (r < 10)
                send_item(spf_pkg::KIND_RELEASE, SLOT_W'($urandom_range(0, 1023)));
            else if (held_slots.size() == 0 || $urandom_range(0, 99) < alloc_pct)
                send_item(spf_pkg::KIND_ALLOC, SLOT_W'($urandom_range(0, 1023)));
            else
                release_random_held();
        end
        calm_traffic = 1'b0;
    endtask

    // reply side: random idling, plus a long hold-off on request
    initial begin : reply_driver
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                rsp_if.ready <= 1'b0;
                idle_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    idle_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        spf_pkg::t_rsp got;
        spf_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (replies_due.size() == 0) begin
                $display("reply %0d: transaction with no reply due", reply_count);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                if (got.slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
                if (got.revision !== want.revision)
                    report_mismatch("revision", 32'(got.revision), 32'(want.revision));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.live_count !== want.live_count)
                    report_mismatch("live_count", 32'(got.live_count), 32'(want.live_count));
            end
            reply_count++;
        end
    end

    initial begin
        error_count    = 0;
        reply_count    = 0;
        calm_traffic   = 1'b0;
        hold_request   = 1'b0;
        init_pool();
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_slot_recycle();
        test_backpressure();
        test_exhaust_and_drain();
        test_random_traffic();

        req_if.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && replies_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
